// ----- rtl/slfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfr_pkg
// Shared types and constants of the sync/length frame receiver.
// ----------------------------------------------------------------------------
package slfr_pkg;

  // Default payload capacity of one frame, in bytes
  localparam int MAX_PAYLOAD_DEF = 32;
  // Length byte counts itself, the command and the checksum
  localparam int LEN_OVERHEAD = 3;
  // Sync byte after reset
  localparam logic [7:0] SYNC_RESET = 8'hAA;
  // Width of a payload length or fill count, enough for the largest capacity (64)
  localparam int LEN_W = 7;

  typedef enum logic [2:0] {
    PH_SYNC    = 3'd0,
    PH_LEN     = 3'd1,
    PH_CMD     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_e;

  // One checked frame, waiting to be drained
  typedef struct packed {
    logic [7:0]       cmd;
    logic [LEN_W-1:0] len;
  } desc_t;

endpackage

// ----- rtl/slfr_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module slfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data between reads
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/slfr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfr_front
// Frame parser: hunts for sync, checks length, stores the payload in the
// free bank of the payload RAM and queues each frame whose checksum matches.
// ----------------------------------------------------------------------------
module slfr_front #(
  parameter int MAX_PAYLOAD = slfr_pkg::MAX_PAYLOAD_DEF,
  localparam int IdxW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          sync_value_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                q_full_i,
  output logic                push_o,
  output slfr_pkg::desc_t     desc_o,
  output logic                ram_we_o,
  output logic [IdxW:0]       ram_waddr_o,
  output logic [7:0]          ram_wdata_o
);

  localparam logic [7:0] MinLen = 8'(slfr_pkg::LEN_OVERHEAD);
  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD + slfr_pkg::LEN_OVERHEAD);

  slfr_pkg::phase_e                phase_q, phase_d;
  logic [slfr_pkg::LEN_W-1:0]      len_q, len_d;
  logic [slfr_pkg::LEN_W-1:0]      fill_q, fill_d;
  logic [slfr_pkg::LEN_W-1:0]      fill_inc;
  logic [7:0]                      total_q, total_d;
  logic [7:0]                      cmd_q, cmd_d;
  logic                            bank_q, bank_d;
  logic                            accept;
  slfr_pkg::phase_e                resync;

  // Both banks held by the back end: no payload write, no push
  assign in_ready_o = !(q_full_i &&
                        (phase_q == slfr_pkg::PH_PAYLOAD || phase_q == slfr_pkg::PH_CHECK));
  assign accept     = in_valid_i && in_ready_o;
  assign fill_inc   = fill_q + 1'b1;
  assign resync     = (rx_byte_i == sync_value_i) ? slfr_pkg::PH_LEN : slfr_pkg::PH_SYNC;

  assign desc_o.cmd  = cmd_q;
  assign desc_o.len  = len_q;
  assign ram_waddr_o = {bank_q, fill_q[IdxW-1:0]};
  assign ram_wdata_o = rx_byte_i;

  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    fill_d   = fill_q;
    total_d  = total_q;
    cmd_d    = cmd_q;
    bank_d   = bank_q;
    push_o   = 1'b0;
    ram_we_o = 1'b0;
    if (accept) begin
      case (phase_q)
        slfr_pkg::PH_SYNC: begin
          if (rx_byte_i == sync_value_i) begin
            phase_d = slfr_pkg::PH_LEN;
          end
        end
        slfr_pkg::PH_LEN: begin
          if (rx_byte_i < MinLen || rx_byte_i > MaxLen) begin
            phase_d = resync;
          end else begin
            len_d   = slfr_pkg::LEN_W'(rx_byte_i - MinLen);
            total_d = rx_byte_i;
            fill_d  = '0;
            phase_d = slfr_pkg::PH_CMD;
          end
        end
        slfr_pkg::PH_CMD: begin
          cmd_d   = rx_byte_i;
          total_d = total_q + rx_byte_i;
          phase_d = (len_q == '0) ? slfr_pkg::PH_CHECK : slfr_pkg::PH_PAYLOAD;
        end
        slfr_pkg::PH_PAYLOAD: begin
          ram_we_o = 1'b1;
          fill_d   = fill_inc;
          total_d  = total_q + rx_byte_i;
          if (fill_inc >= len_q) begin
            phase_d = slfr_pkg::PH_CHECK;
          end
        end
        slfr_pkg::PH_CHECK: begin
          if (rx_byte_i == total_q) begin
            push_o  = 1'b1;
            bank_d  = !bank_q;
            phase_d = slfr_pkg::PH_SYNC;
          end else begin
            phase_d = resync;
          end
        end
        default: begin
          phase_d = slfr_pkg::PH_SYNC;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= slfr_pkg::PH_SYNC;
      len_q   <= '0;
      fill_q  <= '0;
      total_q <= '0;
      cmd_q   <= '0;
      bank_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      fill_q  <= fill_d;
      total_q <= total_d;
      cmd_q   <= cmd_d;
      bank_q  <= bank_d;
    end
  end

endmodule

// ----- rtl/slfr_desc_q.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfr_desc_q
// Two-entry queue of checked frames, one entry per payload bank.
// ----------------------------------------------------------------------------
module slfr_desc_q (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  slfr_pkg::desc_t data_i,
  input  logic            pop_i,
  output logic            valid_o,
  output logic            full_o,
  output slfr_pkg::desc_t data_o
);

  slfr_pkg::desc_t entry_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ----- rtl/slfr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfr_back
// Frame drainer: reads the payload of the oldest queued frame byte by byte
// and presents one registered result per byte, or one for an empty frame.
// ----------------------------------------------------------------------------
module slfr_back #(
  parameter int MAX_PAYLOAD = slfr_pkg::MAX_PAYLOAD_DEF,
  localparam int IdxW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            desc_valid_i,
  input  slfr_pkg::desc_t desc_i,
  output logic            pop_o,
  output logic            ram_re_o,
  output logic [IdxW:0]   ram_raddr_o,
  input  logic [7:0]      ram_rdata_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      frame_cmd_o,
  output logic [5:0]      payload_count_o,
  output logic [4:0]      byte_index_o,
  output logic [7:0]      payload_byte_o,
  output logic            byte_valid_o,
  output logic            last_of_frame_o
);

  logic [slfr_pkg::LEN_W-1:0] k_q, k_d;
  logic [slfr_pkg::LEN_W-1:0] k_inc;
  logic                       bank_q;
  logic                       rd_pend_q;
  logic                       out_valid_q, out_valid_d;
  logic [7:0]                 cmd_q;
  logic [5:0]                 count_q;
  logic [4:0]                 index_q;
  logic                       bvalid_q;
  logic                       last_q;
  logic                       out_free;
  logic                       start;
  logic                       empty_frame;
  logic                       last_byte;

  assign out_free    = !out_valid_q || out_ready_i;
  assign start       = desc_valid_i && !rd_pend_q && out_free;
  assign empty_frame = (desc_i.len == '0);
  assign k_inc       = k_q + 1'b1;
  assign last_byte   = (k_inc == desc_i.len);

  assign ram_re_o    = start && !empty_frame;
  assign ram_raddr_o = {bank_q, k_q[IdxW-1:0]};
  assign pop_o       = start && (empty_frame || last_byte);
  assign k_d         = pop_o ? '0 : (ram_re_o ? k_inc : k_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (rd_pend_q || (start && empty_frame)) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Load the result fields when its read goes out; the RAM registers the byte
  always_ff @(posedge clk_i) begin
    if (start) begin
      cmd_q    <= desc_i.cmd;
      count_q  <= desc_i.len[5:0];
      index_q  <= k_q[4:0];
      bvalid_q <= !empty_frame;
      last_q   <= empty_frame || last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      bank_q      <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      rd_pend_q   <= ram_re_o;
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        bank_q <= !bank_q;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_cmd_o     = cmd_q;
  assign payload_count_o = count_q;
  assign byte_index_o    = index_q;
  assign payload_byte_o  = bvalid_q ? ram_rdata_i : 8'h00;
  assign byte_valid_o    = bvalid_q;
  assign last_of_frame_o = last_q;

endmodule

// ----- rtl/sync_length_frame_receiver_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_frame_receiver_unit
// Sync/length/command frame receiver with additive checksum.
// ----------------------------------------------------------------------------
// The receiver takes one byte per cycle on the input channel and parses
// frames of sync, length (3 to MAX_PAYLOAD+3), command, payload and an 8-bit
// additive checksum. Payload bytes go into one of two banks of a payload RAM;
// a frame whose checksum matches is queued and then drained as one result per
// payload byte (or one result without data for an empty payload). A result
// takes a RAM read, then the output register; reads do not overlap. The input
// channel stalls only at payload and checksum bytes while both banks still
// hold frames that wait to be drained. Bytes between frames are taken at one
// per cycle. The sync byte resets to 0xAA; the user must write it through
// cfg_we_i/cfg_wdata_i only while the receiver is idle; it is not enforced.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver_unit #(
  parameter int MAX_PAYLOAD = slfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] frame_cmd_o,
  output logic [5:0] payload_count_o,
  output logic [4:0] byte_index_o,
  output logic [7:0] payload_byte_o,
  output logic       byte_valid_o,
  output logic       last_of_frame_o
);

  localparam int IdxW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]      sync_value_q;
  logic            q_full;
  logic            q_valid;
  logic            push;
  logic            pop;
  slfr_pkg::desc_t desc_in;
  slfr_pkg::desc_t desc_out;
  logic            ram_we;
  logic [IdxW:0]   ram_waddr;
  logic [7:0]      ram_wdata;
  logic            ram_re;
  logic [IdxW:0]   ram_raddr;
  logic [7:0]      ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_value_q <= slfr_pkg::SYNC_RESET;
    end else if (cfg_we_i) begin
      sync_value_q <= cfg_wdata_i;
    end
  end

  slfr_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sync_value_i (sync_value_q),
    .rx_byte_i    (rx_byte_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .q_full_i     (q_full),
    .push_o       (push),
    .desc_o       (desc_in),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata)
  );

  slfr_desc_q u_desc_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (desc_in),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .data_o  (desc_out)
  );

  slfr_ram #(
    .Width (8),
    .Depth (2 ** (IdxW + 1))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  slfr_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .desc_valid_i    (q_valid),
    .desc_i          (desc_out),
    .pop_o           (pop),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_cmd_o     (frame_cmd_o),
    .payload_count_o (payload_count_o),
    .byte_index_o    (byte_index_o),
    .payload_byte_o  (payload_byte_o),
    .byte_valid_o    (byte_valid_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

// ----- rtl/slfr_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfr_chk
// Port-level checks of the frame receiver's result channel.
// ----------------------------------------------------------------------------
module slfr_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] frame_cmd_o,
  input logic [5:0] payload_count_o,
  input logic [4:0] byte_index_o,
  input logic [7:0] payload_byte_o,
  input logic       byte_valid_o,
  input logic       last_of_frame_o
);

  // a stalled result stays valid with stable command, index, byte and last flag
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_cmd_o) &&
      $stable(byte_index_o) && $stable(payload_byte_o) && $stable(last_of_frame_o))
    else $error("result changed while stalled");

  // an item without data is the whole of an empty frame
  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> payload_count_o == 6'd0 && byte_index_o == 5'd0 &&
      payload_byte_o == 8'h00 && last_of_frame_o)
    else $error("malformed empty-frame result");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |->
      (payload_count_o == 6'd0) || ({1'b0, byte_index_o} < payload_count_o))
    else $error("byte index beyond payload count");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o && last_of_frame_o |->
      byte_index_o == 5'(payload_count_o - 6'd1))
    else $error("last flag away from final byte");

endmodule

bind sync_length_frame_receiver_unit slfr_chk u_slfr_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .frame_cmd_o     (frame_cmd_o),
  .payload_count_o (payload_count_o),
  .byte_index_o    (byte_index_o),
  .payload_byte_o  (payload_byte_o),
  .byte_valid_o    (byte_valid_o),
  .last_of_frame_o (last_of_frame_o)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sync/length frame receiver.
// ----------------------------------------------------------------------------
// A driver streams bytes from a pending queue into the receiver. Every byte
// it hands over runs through a frame parser model that queues the result
// items the frame should produce. A monitor compares each output item field
// by field with the oldest queued item. The run starts with hand-built frames
// and error cases, then sends random frames, noise and broken frames under
// several sync values. Both sides idle in short bursts, and the output side
// stalls once for a long stretch so that the receiver fills and holds off
// its input. The last part runs without idling.
// ----------------------------------------------------------------------------
module tb;

  localparam int FRAME_CAP      = slfr_pkg::MAX_PAYLOAD_DEF;
  localparam int DRAIN_CYCLES   = 24;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [7:0] cmd;
    logic [5:0] count;
    logic [4:0] idx;
    logic [7:0] data;
    logic       valid;
    logic       last;
  } frame_item_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] frame_cmd_o;
  logic [5:0] payload_count_o;
  logic [4:0] byte_index_o;
  logic [7:0] payload_byte_o;
  logic       byte_valid_o;
  logic       last_of_frame_o;

  sync_length_frame_receiver_unit #(
    .MAX_PAYLOAD(FRAME_CAP)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_cmd_o    (frame_cmd_o),
    .payload_count_o(payload_count_o),
    .byte_index_o   (byte_index_o),
    .payload_byte_o (payload_byte_o),
    .byte_valid_o   (byte_valid_o),
    .last_of_frame_o(last_of_frame_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Parser model state
  logic [7:0]       sync_cfg = slfr_pkg::SYNC_RESET;
  slfr_pkg::phase_e parse_ph = slfr_pkg::PH_SYNC;
  logic [5:0]       frame_len = '0;
  logic [5:0]       fill_cnt = '0;
  logic [7:0]       frame_sum = '0;
  logic [7:0]       frame_cmd = '0;
  logic [7:0]       payload_mem [FRAME_CAP];

  frame_item_t expected_items [$];
  logic [7:0]  tx_bytes [$];
  logic [7:0]  frame_data [$];

  int  err_count    = 0;
  int  in_gap       = 0;
  int  out_gap      = 0;
  int  hold_left    = 0;
  int  stall_cycles = 0;
  bit  hold_done    = 1'b0;
  bit  hold_go      = 1'b0;
  bit  idle_on      = 1'b1;

  function automatic void parse_byte(input logic [7:0] b);
    frame_item_t it;
    case (parse_ph)
      slfr_pkg::PH_SYNC: begin
        if (b == sync_cfg) parse_ph = slfr_pkg::PH_LEN;
      end
      slfr_pkg::PH_LEN: begin
        if (b < slfr_pkg::LEN_OVERHEAD || b > FRAME_CAP + slfr_pkg::LEN_OVERHEAD) begin
          if (b == sync_cfg) parse_ph = slfr_pkg::PH_LEN;
          else parse_ph = slfr_pkg::PH_SYNC;
        end else begin
          frame_len = 6'(b - slfr_pkg::LEN_OVERHEAD);
          frame_sum = b;
          fill_cnt  = '0;
          parse_ph  = slfr_pkg::PH_CMD;
        end
      end
      slfr_pkg::PH_CMD: begin
        frame_cmd = b;
        frame_sum = frame_sum + b;
        if (frame_len == 0) parse_ph = slfr_pkg::PH_CHECK;
        else parse_ph = slfr_pkg::PH_PAYLOAD;
      end
      slfr_pkg::PH_PAYLOAD: begin
        if (fill_cnt < FRAME_CAP) payload_mem[fill_cnt[4:0]] = b;
        fill_cnt  = fill_cnt + 6'd1;
        frame_sum = frame_sum + b;
        if (fill_cnt >= frame_len) parse_ph = slfr_pkg::PH_CHECK;
      end
      slfr_pkg::PH_CHECK: begin
        if (b == frame_sum) begin
          it.cmd   = frame_cmd;
          it.count = frame_len;
          if (frame_len == 0) begin
            it.idx   = '0;
            it.data  = '0;
            it.valid = 1'b0;
            it.last  = 1'b1;
            expected_items.push_back(it);
          end else begin
            for (int k = 0; k < frame_len && k < FRAME_CAP; k++) begin
              it.idx   = 5'(k);
              it.data  = payload_mem[5'(k)];
              it.valid = 1'b1;
              it.last  = (k + 1 == frame_len);
              expected_items.push_back(it);
            end
          end
          parse_ph = slfr_pkg::PH_SYNC;
        end else if (b == sync_cfg) begin
          parse_ph = slfr_pkg::PH_LEN;
        end else begin
          parse_ph = slfr_pkg::PH_SYNC;
        end
      end
      default: parse_ph = slfr_pkg::PH_SYNC;
    endcase
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  // Driver: offer the next pending byte, hold it until taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'h00;
      in_gap     <= 0;
    end else begin
      if (in_valid_i && in_ready_o) parse_byte(rx_byte_i);
      if (!in_valid_i || in_ready_o) begin
        if (in_gap != 0) begin
          in_gap     <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          in_gap     <= $urandom_range(0, 4);
          in_valid_i <= 1'b0;
        end else if (tx_bytes.size() != 0) begin
          rx_byte_i  <= tx_bytes.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output ready: random bursts, plus one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap     <= 0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (out_gap != 0) begin
      out_gap     <= out_gap - 1;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_gap     <= $urandom_range(0, 4);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    frame_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_items.size() == 0) begin
        $error("unexpected result item: cmd %0d index %0d", frame_cmd_o, byte_index_o);
        err_count++;
      end else begin
        want = expected_items.pop_front();
        check_field("frame_cmd", 32'(want.cmd), 32'(frame_cmd_o));
        check_field("payload_count", 32'(want.count), 32'(payload_count_o));
        check_field("byte_index", 32'(want.idx), 32'(byte_index_o));
        check_field("payload_byte", 32'(want.data), 32'(payload_byte_o));
        check_field("byte_valid", 32'(want.valid), 32'(byte_valid_o));
        check_field("last_of_frame", 32'(want.last), 32'(last_of_frame_o));
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic fill_payload(input int n);
    frame_data.delete();
    repeat (n) frame_data.push_back(8'($urandom_range(0, 255)));
  endtask

  // Push length, command, payload and checksum (no sync)
  task automatic send_frame_body(input logic [7:0] len_b, input logic [7:0] cmd,
                                 input bit corrupt);
    logic [7:0] sum;
    sum = len_b + cmd;
    tx_bytes.push_back(len_b);
    tx_bytes.push_back(cmd);
    foreach (frame_data[i]) begin
      tx_bytes.push_back(frame_data[i]);
      sum = sum + frame_data[i];
    end
    if (corrupt) begin
      if ($urandom_range(0, 1) == 1 && sync_cfg != sum) sum = sync_cfg;
      else sum = sum ^ 8'($urandom_range(1, 255));
    end
    tx_bytes.push_back(sum);
  endtask

  task automatic queue_traffic(input int budget);
    int base;
    int pick;
    int n;
    base = tx_bytes.size();
    while (tx_bytes.size() - base < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        n = $urandom_range(0, 99);
        if (n < 60) n = $urandom_range(0, 4);
        else if (n < 85) n = $urandom_range(5, FRAME_CAP - 1);
        else n = FRAME_CAP;
        fill_payload(n);
        tx_bytes.push_back(sync_cfg);
        send_frame_body(8'(n + slfr_pkg::LEN_OVERHEAD), 8'($urandom_range(0, 255)),
                        pick >= 70);
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        tx_bytes.push_back(sync_cfg);
        if ($urandom_range(0, 1) == 1) tx_bytes.push_back(8'($urandom_range(0, 2)));
        else tx_bytes.push_back(
          8'($urandom_range(FRAME_CAP + slfr_pkg::LEN_OVERHEAD + 1, 255)));
      end
    end
  endtask

  // Wait until every byte is taken and every item has come out
  task automatic wait_idle();
    do @(negedge clk_i);
    while (tx_bytes.size() != 0 || in_valid_i || expected_items.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [7:0] sync_v, input int budget);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= sync_v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sync_cfg     = sync_v;
    @(negedge clk_i);
    queue_traffic(budget);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Noise with both extreme byte values while hunting
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    // Empty payload
    frame_data.delete();
    tx_bytes.push_back(sync_cfg);
    send_frame_body(8'd3, 8'hFF, 1'b0);
    // Payload with extreme bytes
    frame_data.push_back(8'h00);
    frame_data.push_back(8'hFF);
    tx_bytes.push_back(sync_cfg);
    send_frame_body(8'd5, 8'h00, 1'b0);
    // Length below and above range
    tx_bytes.push_back(sync_cfg);
    tx_bytes.push_back(8'd2);
    tx_bytes.push_back(sync_cfg);
    tx_bytes.push_back(8'(FRAME_CAP + slfr_pkg::LEN_OVERHEAD + 1));
    // Sync repeated as length stays in the length state
    frame_data.delete();
    tx_bytes.push_back(sync_cfg);
    tx_bytes.push_back(sync_cfg);
    send_frame_body(8'd3, 8'h5A, 1'b0);
    // Bad checksum equal to sync resyncs straight into the next length
    tx_bytes.push_back(sync_cfg);
    tx_bytes.push_back(8'd4);
    tx_bytes.push_back(8'h11);
    tx_bytes.push_back(8'h22);
    tx_bytes.push_back(sync_cfg);
    frame_data.push_back(8'h44);
    send_frame_body(8'd4, 8'h33, 1'b0);

    run_phase(8'h00, 55);
    run_phase(8'hFF, 85);
    // Hold off the output while bytes keep coming
    hold_go <= 1'b1;
    run_phase(8'd3, 50);
    run_phase(8'(FRAME_CAP + slfr_pkg::LEN_OVERHEAD), 50);
    wait_idle();
    idle_on <= 1'b0;
    run_phase(8'($urandom_range(0, 255)), 55);
    wait_idle();

    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
